// ----- sv/sqg_pkg.sv -----
`default_nettype none

package sqg_pkg;

   localparam int CNT_W       = 5;
   localparam int GATE_W      = 16;
   localparam int GATE_FRAC   = 14;
   localparam int ROUND_HALF  = 1 << (GATE_FRAC - 1);

   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = 3;
   localparam int FIFO_CNT_W  = 4;

   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   localparam logic [31:0] GATE_00_RESET = 32'h0000_4000;
   localparam logic [31:0] GATE_01_RESET = 32'h0000_0000;
   localparam logic [31:0] GATE_10_RESET = 32'h0000_0000;
   localparam logic [31:0] GATE_11_RESET = 32'h4000_0000;
   localparam logic [3:0]  TARGET_RESET  = 4'd0;
   localparam logic [3:0]  QCOUNT_RESET  = 4'd10;

   typedef enum logic [2:0] {
      REG_GATE_00,
      REG_GATE_01,
      REG_GATE_10,
      REG_GATE_11,
      REG_TARGET_QUBIT,
      REG_QUBIT_COUNT
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_HOLD,
      KIND_PASS,
      KIND_PAIR
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic          end_lo;
      logic          end_hi;
   } stage_ctl_type;

   typedef struct packed {
      logic [31:0] gate_00;
      logic [31:0] gate_01;
      logic [31:0] gate_10;
      logic [31:0] gate_11;
      logic [3:0]  target_qubit;
      logic [3:0]  qubit_count;
   } csr_cfg_type;

endpackage

`default_nettype wire

// ----- sv/sqg_csr.sv -----
`default_nettype none

module sqg_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sqg_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [sqg_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [sqg_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output sqg_pkg::csr_cfg_type         cfg
);
   import sqg_pkg::*;

   csr_cfg_type cfg_ff;
   csr_cfg_type cfg_in;
   logic        wr_en;
   logic [2:0]  reg_sel;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_GATE_00:      cfg_in.gate_00      = csr_pwdata;
            REG_GATE_01:      cfg_in.gate_01      = csr_pwdata;
            REG_GATE_10:      cfg_in.gate_10      = csr_pwdata;
            REG_GATE_11:      cfg_in.gate_11      = csr_pwdata;
            REG_TARGET_QUBIT: cfg_in.target_qubit = csr_pwdata[3:0];
            REG_QUBIT_COUNT:  cfg_in.qubit_count  = csr_pwdata[3:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GATE_00:      csr_prdata = cfg_ff.gate_00;
         REG_GATE_01:      csr_prdata = cfg_ff.gate_01;
         REG_GATE_10:      csr_prdata = cfg_ff.gate_10;
         REG_GATE_11:      csr_prdata = cfg_ff.gate_11;
         REG_TARGET_QUBIT: csr_prdata = {28'd0, cfg_ff.target_qubit};
         REG_QUBIT_COUNT:  csr_prdata = {28'd0, cfg_ff.qubit_count};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_00      <= GATE_00_RESET;
         cfg_ff.gate_01      <= GATE_01_RESET;
         cfg_ff.gate_10      <= GATE_10_RESET;
         cfg_ff.gate_11      <= GATE_11_RESET;
         cfg_ff.target_qubit <= TARGET_RESET;
         cfg_ff.qubit_count  <= QCOUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/sqg_front.sv -----
`default_nettype none

module sqg_front #(
   parameter int MAX_QUBITS = 10,
   parameter int AMP_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [AMP_WIDTH-1:0]   amp_real,
   input  logic signed [AMP_WIDTH-1:0]   amp_imag,
   input  logic [3:0]                    target_qubit,
   input  logic [3:0]                    qubit_count,
   output sqg_pkg::item_kind_type        acc_kind,
   output sqg_pkg::stage_ctl_type        s1_ctl,
   output logic [MAX_QUBITS-1:0]         s1_row_lo,
   output logic [MAX_QUBITS-1:0]         s1_row_hi,
   output logic signed [AMP_WIDTH-1:0]   s1_v0_re,
   output logic signed [AMP_WIDTH-1:0]   s1_v0_im,
   output logic signed [AMP_WIDTH-1:0]   s1_v1_re,
   output logic signed [AMP_WIDTH-1:0]   s1_v1_im
);
   import sqg_pkg::*;

   localparam int BUF_AW    = (MAX_QUBITS > 1) ? MAX_QUBITS - 1 : 1;
   localparam int BUF_DEPTH = 2 ** BUF_AW;

   logic [CNT_W-1:0]       nbits;
   logic                   pass;
   logic [MAX_QUBITS-1:0]  last_row;
   logic [MAX_QUBITS-1:0]  low_mask;
   logic [MAX_QUBITS-1:0]  step;
   logic [MAX_QUBITS-1:0]  row;
   logic [MAX_QUBITS-1:0]  row_lo;
   logic [BUF_AW-1:0]      addr;

   logic [MAX_QUBITS-1:0]  row_ff;
   logic [MAX_QUBITS-1:0]  row_in;
   stage_ctl_type          ctl_ff;
   stage_ctl_type          ctl_in;
   logic [MAX_QUBITS-1:0]  row_lo_ff;
   logic [MAX_QUBITS-1:0]  row_hi_ff;
   logic [2*AMP_WIDTH-1:0] v0_ff;
   logic [2*AMP_WIDTH-1:0] v1_ff;

   logic [2*AMP_WIDTH-1:0] pair_buf_mem [BUF_DEPTH];

   always_comb begin
      nbits = (CNT_W'(qubit_count) > CNT_W'(MAX_QUBITS)) ? CNT_W'(MAX_QUBITS)
                                                         : CNT_W'(qubit_count);
      pass  = CNT_W'(target_qubit) >= nbits;
      for (int i = 0; i < MAX_QUBITS; i++) begin
         last_row[i] = CNT_W'(i) < nbits;
         low_mask[i] = CNT_W'(i) < CNT_W'(target_qubit);
         step[i]     = CNT_W'(i) == CNT_W'(target_qubit);
      end
      row    = row_ff & last_row;
      row_lo = row - step;
      addr   = BUF_AW'(row & low_mask);
      if (pass) begin
         acc_kind = KIND_PASS;
      end else if ((row & step) != '0) begin
         acc_kind = KIND_PAIR;
      end else begin
         acc_kind = KIND_HOLD;
      end
   end

   always_comb begin
      row_in = row_ff;
      ctl_in = '{kind: KIND_NONE, end_lo: 1'b0, end_hi: 1'b0};
      if (accept) begin
         row_in        = (row + MAX_QUBITS'(1)) & last_row;
         ctl_in.kind   = acc_kind;
         ctl_in.end_lo = row_lo == last_row;
         ctl_in.end_hi = row == last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         ctl_ff <= '{kind: KIND_NONE, end_lo: 1'b0, end_hi: 1'b0};
      end else begin
         row_ff <= row_in;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_lo_ff <= row_lo;
         row_hi_ff <= row;
         v1_ff     <= {amp_imag, amp_real};
      end
   end

   // held rows; the read of a pairing row lands in v0_ff with the item
   always_ff @(posedge clock) begin
      if (accept && acc_kind == KIND_HOLD) begin
         pair_buf_mem[addr] <= {amp_imag, amp_real};
      end
      if (accept) begin
         v0_ff <= pair_buf_mem[addr];
      end
   end

   assign s1_ctl    = ctl_ff;
   assign s1_row_lo = row_lo_ff;
   assign s1_row_hi = row_hi_ff;
   assign s1_v0_re  = v0_ff[AMP_WIDTH-1:0];
   assign s1_v0_im  = v0_ff[2*AMP_WIDTH-1:AMP_WIDTH];
   assign s1_v1_re  = v1_ff[AMP_WIDTH-1:0];
   assign s1_v1_im  = v1_ff[2*AMP_WIDTH-1:AMP_WIDTH];

endmodule

`default_nettype wire

// ----- sv/sqg_butterfly.sv -----
`default_nettype none

module sqg_butterfly #(
   parameter int AMP_WIDTH = 16
) (
   input  logic                          clock,
   input  logic [31:0]                   gate_a,
   input  logic [31:0]                   gate_b,
   input  logic signed [AMP_WIDTH-1:0]   r0,
   input  logic signed [AMP_WIDTH-1:0]   i0,
   input  logic signed [AMP_WIDTH-1:0]   r1,
   input  logic signed [AMP_WIDTH-1:0]   i1,
   output logic signed [AMP_WIDTH-1:0]   out_re,
   output logic signed [AMP_WIDTH-1:0]   out_im
);
   import sqg_pkg::*;

   localparam int PW = AMP_WIDTH + GATE_W;
   localparam int RW = PW - GATE_FRAC;
   localparam int SW = RW + 2;
   localparam logic signed [SW-1:0] SAT_HI =
      {{(SW - AMP_WIDTH + 1){1'b0}}, {(AMP_WIDTH - 1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO =
      {{(SW - AMP_WIDTH + 1){1'b1}}, {(AMP_WIDTH - 1){1'b0}}};

   logic signed [GATE_W-1:0]    gk [8];
   logic signed [AMP_WIDTH-1:0] ak [8];
   logic signed [PW-1:0]        prod [8];
   logic signed [PW-1:0]        prod_rnd [8];
   logic signed [RW-1:0]        rnd_in [8];
   logic signed [RW-1:0]        rnd_ff [8];
   logic signed [SW-1:0]        sum_re;
   logic signed [SW-1:0]        sum_im;

   // real part terms 0..3, imaginary part terms 4..7
   always_comb begin
      gk[0] = gate_a[31:16];  ak[0] = r0;
      gk[1] = gate_a[15:0];   ak[1] = i0;
      gk[2] = gate_b[31:16];  ak[2] = r1;
      gk[3] = gate_b[15:0];   ak[3] = i1;
      gk[4] = gate_a[31:16];  ak[4] = i0;
      gk[5] = gate_a[15:0];   ak[5] = r0;
      gk[6] = gate_b[31:16];  ak[6] = i1;
      gk[7] = gate_b[15:0];   ak[7] = r1;
      for (int k = 0; k < 8; k++) begin
         prod[k]     = PW'(gk[k]) * PW'(ak[k]);
         prod_rnd[k] = prod[k] + PW'(ROUND_HALF);
         rnd_in[k]   = prod_rnd[k][PW-1:GATE_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
   end

   always_comb begin
      sum_re = SW'(rnd_ff[0]) - SW'(rnd_ff[1]) + SW'(rnd_ff[2]) - SW'(rnd_ff[3]);
      sum_im = SW'(rnd_ff[4]) + SW'(rnd_ff[5]) + SW'(rnd_ff[6]) + SW'(rnd_ff[7]);
      if (sum_re > SAT_HI) begin
         out_re = SAT_HI[AMP_WIDTH-1:0];
      end else if (sum_re < SAT_LO) begin
         out_re = SAT_LO[AMP_WIDTH-1:0];
      end else begin
         out_re = sum_re[AMP_WIDTH-1:0];
      end
      if (sum_im > SAT_HI) begin
         out_im = SAT_HI[AMP_WIDTH-1:0];
      end else if (sum_im < SAT_LO) begin
         out_im = SAT_LO[AMP_WIDTH-1:0];
      end else begin
         out_im = sum_im[AMP_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- sv/sqg_out_fifo.sv -----
`default_nettype none

module sqg_out_fifo #(
   parameter int WIDTH = 44
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_first,
   input  logic              wr_second,
   input  logic [WIDTH-1:0]  wr_data0,
   input  logic [WIDTH-1:0]  wr_data1,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [WIDTH-1:0]  out_data
);
   import sqg_pkg::*;

   logic [WIDTH-1:0]      entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_next;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic [FIFO_CNT_W-1:0] count_in;
   logic [FIFO_CNT_W-1:0] n_wr;
   logic                  rd;

   always_comb begin
      rd          = out_valid && out_ready;
      n_wr        = FIFO_CNT_W'(wr_first) + FIFO_CNT_W'(wr_second);
      wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + FIFO_PTR_W'(n_wr);
      rd_ptr_in   = rd_ptr_ff + FIFO_PTR_W'(rd);
      count_in    = count_ff + n_wr - FIFO_CNT_W'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_first) begin
         entry_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr_second) begin
         entry_ff[wr_ptr_next] <= wr_data1;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- sv/single_qubit_gate_stream.sv -----
// A result passes through the buffer read, the products, and the sum and
// saturation into the output queue before it is offered.
// Throughput: one input transfer per cycle while at least two output queue
// slots are unreserved; a pairing row yields two results, written together
// into the eight-entry output queue. Reset: row counter, queue and pipeline
// control cleared, gate registers set to diag(i, 1); the pair buffer is not cleared.
`default_nettype none

module single_qubit_gate_stream #(
   parameter int MAX_QUBITS = 10,
   parameter int AMP_WIDTH  = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // amp_real, amp_imag
   input  logic [((2*AMP_WIDTH+7)/8)*8-1:0]          req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // row_index, out_real, out_imag
   output logic [((MAX_QUBITS+2*AMP_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic                                      rsp_tlast,
   // column_end
   output logic                                      rsp_tuser,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [sqg_pkg::CSR_AW-1:0]                csr_paddr,
   input  logic [sqg_pkg::CSR_DW-1:0]                csr_pwdata,
   output logic [sqg_pkg::CSR_DW-1:0]                csr_prdata,
   output logic                                      csr_pready
);
   import sqg_pkg::*;

   localparam int OUT_DW = ((MAX_QUBITS + 2*AMP_WIDTH + 7) / 8) * 8;
   localparam int EW     = MAX_QUBITS + 2*AMP_WIDTH + 2;

   csr_cfg_type                 cfg;
   logic                        accept;
   item_kind_type               acc_kind;
   stage_ctl_type               s1_ctl;
   logic [MAX_QUBITS-1:0]       s1_row_lo;
   logic [MAX_QUBITS-1:0]       s1_row_hi;
   logic signed [AMP_WIDTH-1:0] s1_v0_re;
   logic signed [AMP_WIDTH-1:0] s1_v0_im;
   logic signed [AMP_WIDTH-1:0] s1_v1_re;
   logic signed [AMP_WIDTH-1:0] s1_v1_im;

   stage_ctl_type               ctl2_ff;
   logic [MAX_QUBITS-1:0]       row_lo2_ff;
   logic [MAX_QUBITS-1:0]       row_hi2_ff;
   logic signed [AMP_WIDTH-1:0] v1_re2_ff;
   logic signed [AMP_WIDTH-1:0] v1_im2_ff;

   logic signed [AMP_WIDTH-1:0] a_re;
   logic signed [AMP_WIDTH-1:0] a_im;
   logic signed [AMP_WIDTH-1:0] b_re;
   logic signed [AMP_WIDTH-1:0] b_im;

   logic                        wr_first;
   logic                        wr_second;
   logic [EW-1:0]               entry0;
   logic [EW-1:0]               entry1;
   logic [EW-1:0]               head;

   logic [FIFO_CNT_W-1:0]       res_ff;
   logic [FIFO_CNT_W-1:0]       res_in;
   logic [FIFO_CNT_W-1:0]       n_acc;
   logic                        rsp_xfer;

   sqg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sqg_front #(
      .MAX_QUBITS (MAX_QUBITS),
      .AMP_WIDTH  (AMP_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .amp_real     (req_tdata[AMP_WIDTH-1:0]),
      .amp_imag     (req_tdata[2*AMP_WIDTH-1:AMP_WIDTH]),
      .target_qubit (cfg.target_qubit),
      .qubit_count  (cfg.qubit_count),
      .acc_kind     (acc_kind),
      .s1_ctl       (s1_ctl),
      .s1_row_lo    (s1_row_lo),
      .s1_row_hi    (s1_row_hi),
      .s1_v0_re     (s1_v0_re),
      .s1_v0_im     (s1_v0_im),
      .s1_v1_re     (s1_v1_re),
      .s1_v1_im     (s1_v1_im)
   );

   sqg_butterfly #(.AMP_WIDTH(AMP_WIDTH)) u_bfly_lo (
      .clock  (clock),
      .gate_a (cfg.gate_00),
      .gate_b (cfg.gate_01),
      .r0     (s1_v0_re),
      .i0     (s1_v0_im),
      .r1     (s1_v1_re),
      .i1     (s1_v1_im),
      .out_re (a_re),
      .out_im (a_im)
   );

   sqg_butterfly #(.AMP_WIDTH(AMP_WIDTH)) u_bfly_hi (
      .clock  (clock),
      .gate_a (cfg.gate_10),
      .gate_b (cfg.gate_11),
      .r0     (s1_v0_re),
      .i0     (s1_v0_im),
      .r1     (s1_v1_re),
      .i1     (s1_v1_im),
      .out_re (b_re),
      .out_im (b_im)
   );

   // queue slots are reserved at input transfer, so the pipeline never stalls
   always_comb begin
      accept     = req_tvalid && req_tready;
      rsp_xfer   = rsp_tvalid && rsp_tready;
      n_acc      = '0;
      if (accept) begin
         case (acc_kind)
            KIND_PASS: n_acc = FIFO_CNT_W'(1);
            KIND_PAIR: n_acc = FIFO_CNT_W'(2);
            default:   n_acc = '0;
         endcase
      end
      res_in     = res_ff + n_acc - FIFO_CNT_W'(rsp_xfer);
      req_tready = res_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff  <= '0;
         ctl2_ff <= '{kind: KIND_NONE, end_lo: 1'b0, end_hi: 1'b0};
      end else begin
         res_ff  <= res_in;
         ctl2_ff <= s1_ctl;
      end
   end

   always_ff @(posedge clock) begin
      row_lo2_ff <= s1_row_lo;
      row_hi2_ff <= s1_row_hi;
      v1_re2_ff  <= s1_v1_re;
      v1_im2_ff  <= s1_v1_im;
   end

   always_comb begin
      wr_first  = ctl2_ff.kind == KIND_PASS || ctl2_ff.kind == KIND_PAIR;
      wr_second = ctl2_ff.kind == KIND_PAIR;
      if (ctl2_ff.kind == KIND_PAIR) begin
         entry0 = {ctl2_ff.end_lo, 1'b0, a_im, a_re, row_lo2_ff};
      end else begin
         entry0 = {ctl2_ff.end_hi, 1'b1, v1_im2_ff, v1_re2_ff, row_hi2_ff};
      end
      entry1 = {ctl2_ff.end_hi, 1'b1, b_im, b_re, row_hi2_ff};
   end

   sqg_out_fifo #(.WIDTH(EW)) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_first  (wr_first),
      .wr_second (wr_second),
      .wr_data0  (entry0),
      .wr_data1  (entry1),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = OUT_DW'(head[EW-3:0]);
   assign rsp_tlast = head[EW-2];
   assign rsp_tuser = head[EW-1];

   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      res_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("reserved queue slots exceed depth");

   a_rsp_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> res_ff != '0)
      else $error("result offered without a reserved slot");

   a_pair_reserved: assert property (@(posedge clock) disable iff (reset)
      ctl2_ff.kind == KIND_PAIR |-> res_ff >= FIFO_CNT_W'(2))
      else $error("pair results without two reserved slots");

   a_pass_reserved: assert property (@(posedge clock) disable iff (reset)
      ctl2_ff.kind == KIND_PASS |-> res_ff != '0)
      else $error("pass-through result without a reserved slot");

endmodule

`default_nettype wire

// ----- sim/gate_pair_checker.sv -----
`default_nettype none

module gate_pair_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   // amp_real, amp_imag
   input  logic [31:0]                 req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // row_index, out_real, out_imag
   input  logic [47:0]                 rsp_tdata,
   input  logic                        rsp_tlast,
   // column_end
   input  logic                        rsp_tuser,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sqg_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sqg_pkg::CSR_DW-1:0]  csr_pwdata,
   input  logic                        csr_pready,
   output int                          mismatches,
   output int                          pending,
   output int                          results_checked
);
   import sqg_pkg::*;

   localparam int ROW_W      = 10;
   localparam int MAX_Q      = 10;
   localparam int HELD_DEPTH = 512;
   localparam int EXP_DEPTH  = 64;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [15:0]      re;
      logic [15:0]      im;
      logic             run_last;
      logic             col_end;
   } amp_result_type;

   amp_result_type expected_mem [EXP_DEPTH];
   int             exp_head = 0;
   int             exp_tail = 0;

   logic [31:0]      gate_00 = GATE_00_RESET;
   logic [31:0]      gate_01 = GATE_01_RESET;
   logic [31:0]      gate_10 = GATE_10_RESET;
   logic [31:0]      gate_11 = GATE_11_RESET;
   logic [3:0]       target  = TARGET_RESET;
   logic [3:0]       qcount  = QCOUNT_RESET;
   logic [ROW_W-1:0] row_cnt = '0;
   logic [15:0]      held_re [HELD_DEPTH];
   logic [15:0]      held_im [HELD_DEPTH];

   function automatic void queue_result(input amp_result_type e);
      expected_mem[exp_tail % EXP_DEPTH] = e;
      exp_tail++;
   endfunction

   // product rounded back to Q1.14, halves towards +inf
   function automatic longint round_q14(input longint p);
      return (p + ROUND_HALF) >>> GATE_FRAC;
   endfunction

   function automatic logic [15:0] clamp_amp(input longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // ga*v0 + gb*v1 as {real, imag}
   function automatic logic [31:0] mix_entry(input logic [31:0] ga, input logic [31:0] gb,
                                             input logic signed [15:0] r0,
                                             input logic signed [15:0] i0,
                                             input logic signed [15:0] r1,
                                             input logic signed [15:0] i1);
      longint ar, ai, br, bi, sum_re, sum_im;
      ar = $signed(ga[31:16]);
      ai = $signed(ga[15:0]);
      br = $signed(gb[31:16]);
      bi = $signed(gb[15:0]);
      sum_re = round_q14(ar * r0) - round_q14(ai * i0) + round_q14(br * r1) - round_q14(bi * i1);
      sum_im = round_q14(ar * i0) + round_q14(ai * r0) + round_q14(br * i1) + round_q14(bi * r1);
      return {clamp_amp(sum_re), clamp_amp(sum_im)};
   endfunction

   function automatic void predict_rows(input logic [31:0] amp);
      logic signed [15:0] vr, vi, r0, i0;
      logic [ROW_W-1:0]   last_row, r, step, lo_row;
      logic [8:0]         addr;
      logic [31:0]        lo, hi;
      int                 nbits;
      vr       = amp[15:0];
      vi       = amp[31:16];
      nbits    = (qcount > MAX_Q) ? MAX_Q : int'(qcount);
      last_row = ROW_W'((1 << nbits) - 1);
      r        = row_cnt & last_row;
      row_cnt  = (r + 1'b1) & last_row;
      if (target >= nbits) begin
         queue_result(amp_result_type'({r, vr, vi, 1'b1, r == last_row}));
         return;
      end
      step = ROW_W'(1 << target);
      addr = 9'(r & (step - 1'b1));
      if ((r & step) == '0) begin
         held_re[addr] = vr;
         held_im[addr] = vi;
      end else begin
         r0     = held_re[addr];
         i0     = held_im[addr];
         lo     = mix_entry(gate_00, gate_01, r0, i0, vr, vi);
         hi     = mix_entry(gate_10, gate_11, r0, i0, vr, vi);
         lo_row = r - step;
         queue_result(amp_result_type'({lo_row, lo[31:16], lo[15:0], 1'b0,
                                        lo_row == last_row}));
         queue_result(amp_result_type'({r, hi[31:16], hi[15:0], 1'b1,
                                        r == last_row}));
      end
   endfunction

   task automatic check_result();
      amp_result_type got, want;
      got = {rsp_tdata[9:0], rsp_tdata[25:10], rsp_tdata[41:26], rsp_tlast, rsp_tuser};
      results_checked++;
      if (exp_tail == exp_head) begin
         $error("unexpected result transfer, row_index %0d", got.row);
         mismatches++;
         return;
      end
      want = expected_mem[exp_head % EXP_DEPTH];
      exp_head++;
      if (got.row !== want.row) begin
         $error("row_index expected %0d got %0d", want.row, got.row);
         mismatches++;
      end
      if (got.re !== want.re) begin
         $error("out_real expected %0d got %0d", $signed(want.re), $signed(got.re));
         mismatches++;
      end
      if (got.im !== want.im) begin
         $error("out_imag expected %0d got %0d", $signed(want.im), $signed(got.im));
         mismatches++;
      end
      if (got.run_last !== want.run_last) begin
         $error("run_last expected %0d got %0d", want.run_last, got.run_last);
         mismatches++;
      end
      if (got.col_end !== want.col_end) begin
         $error("column_end expected %0d got %0d", want.col_end, got.col_end);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gate_00         = GATE_00_RESET;
         gate_01         = GATE_01_RESET;
         gate_10         = GATE_10_RESET;
         gate_11         = GATE_11_RESET;
         target          = TARGET_RESET;
         qcount          = QCOUNT_RESET;
         row_cnt         = '0;
         exp_head        = 0;
         exp_tail        = 0;
         mismatches      = 0;
         results_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[4:2]))
               REG_GATE_00:      gate_00 = csr_pwdata;
               REG_GATE_01:      gate_01 = csr_pwdata;
               REG_GATE_10:      gate_10 = csr_pwdata;
               REG_GATE_11:      gate_11 = csr_pwdata;
               REG_TARGET_QUBIT: target  = csr_pwdata[3:0];
               REG_QUBIT_COUNT:  qcount  = csr_pwdata[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_rows(req_tdata);
      end
      pending = exp_tail - exp_head;
   end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none

module tb;
   import sqg_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int ITEM_TARGET   = 1050;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_Q         = 10;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [47:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tuser;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int mismatches, pending, results_checked;
   int tx_idle_pct    = 28;
   int rx_idle_pct    = 53;
   int items_sent     = 0;
   int settings_used  = 0;
   int idle_cycles    = 0;

   // stimulus-side view of the row counter and of which buffer slots hold data
   int         row_pos    = 0;
   logic [3:0] cur_target = TARGET_RESET;
   logic [3:0] cur_count  = QCOUNT_RESET;
   bit         held_valid [512];

   single_qubit_gate_stream u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   gate_pair_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatches      (mismatches),
      .pending         (pending),
      .results_checked (results_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // true if no pairing row left in this column would read a slot never filled
   function automatic bit column_safe(input logic [3:0] t, input logic [3:0] q);
      int nb, step, last, r, rr;
      nb = (q > MAX_Q) ? MAX_Q : int'(q);
      if (t >= nb) return 1'b1;
      step = 1 << t;
      last = (1 << nb) - 1;
      r    = row_pos & last;
      for (rr = r; rr <= last; rr++) begin
         if ((rr & step) != 0 && rr - step < r && !held_valid[rr & (step - 1)]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [15:0] extreme_half();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'h4000;
      endcase
   endfunction

   function automatic logic [31:0] rand_gate();
      int a, b;
      a = $urandom_range(32768) - 16384;
      b = $urandom_range(32768) - 16384;
      case ($urandom_range(3))
         0: return $urandom;
         1: return {16'(a), 16'(b)};
         2: return {extreme_half(), extreme_half()};
         default: return {($urandom_range(1) ? 16'h2D41 : 16'hD2BF), 16'h0000};
      endcase
   endfunction

   function automatic logic [31:0] rand_amp();
      int a, b;
      a = $urandom_range(23170) - 11585;
      b = $urandom_range(23170) - 11585;
      case ($urandom_range(3))
         0, 1: return $urandom;
         2: return {16'(b), 16'(a)};
         default: return {extreme_half(), extreme_half()};
      endcase
   endfunction

   task automatic send_amp(input logic [31:0] d);
      int gap, nb, last, r;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (items_sent >= 700) begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end else if (items_sent >= 350) begin
         tx_idle_pct = 53;
         rx_idle_pct = 28;
      end
      nb      = (cur_count > MAX_Q) ? MAX_Q : int'(cur_count);
      last    = (1 << nb) - 1;
      r       = row_pos & last;
      row_pos = (r + 1) & last;
      if (cur_target < nb && (r & (1 << cur_target)) == 0)
         held_valid[r & ((1 << cur_target) - 1)] = 1'b1;
   endtask

   // hold the sender until every result is out and the pipeline is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] g00, input logic [31:0] g01,
                            input logic [31:0] g10, input logic [31:0] g11,
                            input logic [3:0] t, input logic [3:0] q);
      settle();
      write_reg(REG_GATE_00, g00);
      write_reg(REG_GATE_01, g01);
      write_reg(REG_GATE_10, g10);
      write_reg(REG_GATE_11, g11);
      write_reg(REG_TARGET_QUBIT, {28'd0, t});
      write_reg(REG_QUBIT_COUNT, {28'd0, q});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      cur_target = t;
      cur_count  = q;
      settings_used++;
   endtask

   initial begin
      logic [31:0] g00, g01, g10, g11;
      logic [3:0]  tq, qc;
      int          nb, n, tries;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // diag(i, 1) gate after reset, amplitude extremes
      send_amp(32'h8000_8000);
      send_amp(32'h7FFF_7FFF);
      send_amp(32'h0000_0000);
      send_amp(32'hFFFF_0001);

      // extreme gate entries, saturating sums
      configure(32'h8000_8000, 32'h7FFF_7FFF, 32'h8000_7FFF, 32'h7FFF_8000, 4'd1, 4'd2);
      send_amp(32'h8000_7FFF);
      send_amp(32'h7FFF_8000);
      send_amp(32'h7FFF_7FFF);
      send_amp(32'h8000_8000);

      // Hadamard, then target moved part way through the column
      configure(32'h2D41_0000, 32'h2D41_0000, 32'h2D41_0000, 32'hD2BF_0000, 4'd0, 4'd3);
      repeat (3) send_amp(rand_amp());
      configure(32'h2D41_0000, 32'h2D41_0000, 32'h2D41_0000, 32'hD2BF_0000, 4'd1, 4'd3);
      repeat (5) send_amp(rand_amp());

      // target beyond the column: straight through
      configure(32'h2D41_0000, 32'h2D41_0000, 32'h2D41_0000, 32'hD2BF_0000, 4'd5, 4'd3);
      repeat (2) send_amp(rand_amp());

      // single-row column
      configure(32'h2D41_0000, 32'h2D41_0000, 32'h2D41_0000, 32'hD2BF_0000, 4'd0, 4'd0);
      repeat (2) send_amp(rand_amp());

      // oversized qubit count clamps
      configure(32'h2D41_0000, 32'h2D41_0000, 32'h2D41_0000, 32'hD2BF_0000, 4'd0, 4'd15);
      repeat (2) send_amp(rand_amp());
      configure(32'h2D41_0000, 32'h2D41_0000, 32'h2D41_0000, 32'hD2BF_0000, 4'd15, 4'd15);
      send_amp(rand_amp());

      while (items_sent < ITEM_TARGET) begin
         g00   = rand_gate();
         g01   = rand_gate();
         g10   = rand_gate();
         g11   = rand_gate();
         tries = 0;
         do begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: qc = 4'($urandom_range(4, 1));
               6, 7:             qc = 4'($urandom_range(9, 5));
               8:                qc = 4'($urandom_range(15, 10));
               default:          qc = 4'd0;
            endcase
            nb = (qc > MAX_Q) ? MAX_Q : int'(qc);
            if (nb > 0 && $urandom_range(4) != 0) tq = 4'($urandom_range(nb - 1));
            else tq = 4'($urandom_range(15));
            tries++;
         end while (!column_safe(tq, qc) && tries < 8);
         if (!column_safe(tq, qc)) tq = 4'd15;
         configure(g00, g01, g10, g11, tq, qc);
         if (nb <= 5) n = (1 << nb) * $urandom_range(3, 1);
         else n = $urandom_range(64, 8);
         if ($urandom_range(5) == 0) n = $urandom_range(8, 1);
         repeat (n) send_amp(rand_amp());
      end

      settle();
      $display("Sent %0d amplitudes under %0d gate and qubit settings, counts 0 to 15,",
               items_sent, settings_used);
      $display("targets in and out of range; %0d result transfers compared, %0d mismatches.",
               results_checked, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
